/* hw/rtl/cllm_pkg.sv */
// shared types, constants and helpers for the cursor linked list manager
`default_nettype none

package cllm_pkg;

  localparam int SLOTS     = 16;
  localparam int NUM_LISTS = 4;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int LIST_W    = $clog2(NUM_LISTS);
  localparam int STEP_W    = $clog2(SLOTS + 1);
  localparam int PTR_W     = 5;
  localparam int ELEM_W    = 8;
  localparam int UPC_W     = 4;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [UPC_W-1:0]  upc_t;

  localparam ptr_t PTR_NULL = '1;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_INS_POS   = 2'd2,
    ACT_DEL_FRONT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ALLOC,
    OP_WALK_INIT,
    OP_WALK,
    OP_LINK_NEW,
    OP_LINK_CUR,
    OP_LINK_FRONT,
    OP_DELETE,
    OP_FULL
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_VALID,
    C_IS_DEL,
    C_FREE_EMPTY,
    C_FRONT,
    C_WALK_MORE,
    C_OUT_FREE
  } cond_e;

  // microprogram addresses
  localparam upc_t STEP_FETCH      = 4'd0;
  localparam upc_t STEP_DISPATCH   = 4'd1;
  localparam upc_t STEP_CHECK_FREE = 4'd2;
  localparam upc_t STEP_ALLOC      = 4'd3;
  localparam upc_t STEP_WALK_INIT  = 4'd4;
  localparam upc_t STEP_WALK       = 4'd5;
  localparam upc_t STEP_LINK_NEW   = 4'd6;
  localparam upc_t STEP_LINK_CUR   = 4'd7;
  localparam upc_t STEP_LINK_FRONT = 4'd8;
  localparam upc_t STEP_DELETE     = 4'd9;
  localparam upc_t STEP_FULL       = 4'd10;
  localparam upc_t STEP_EMIT       = 4'd11;

  typedef struct packed {
    logic   accept;
    logic   emit;
    dp_op_e op;
    cond_e  cond;
    upc_t   target;
    logic   stay_else;
  } ucode_t;

  typedef struct packed {
    logic is_del;
    logic free_empty;
    logic front;
    logic walk_more;
  } dp_flags_t;

  typedef struct packed {
    status_e status;
    ptr_t    slot;
    elem_t   removed;
    ptr_t    new_head;
  } dp_result_t;

  function automatic logic is_slot(ptr_t p);
    return p < PTR_W'(SLOTS);
  endfunction

  function automatic ptr_t valid_or_null(ptr_t p);
    return is_slot(p) ? p : PTR_NULL;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cllm_if.sv */
// valid/ready channels for requests and results
`default_nettype none

interface cllm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] list_sel;
  logic [7:0] element;
  logic [4:0] position;

  modport source (output valid, action, list_sel, element, position, input ready);
  modport sink   (input valid, action, list_sel, element, position, output ready);
endinterface

interface cllm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot;
  logic [7:0] removed_element;
  logic [4:0] new_head;

  modport source (output valid, status, slot, removed_element, new_head, input ready);
  modport sink   (input valid, status, slot, removed_element, new_head, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cllm_ucode_rom.sv */
// microprogram table: one control word per sequencer step
`default_nettype none

module cllm_ucode_rom (
  input  cllm_pkg::upc_t   upc_i,
  output cllm_pkg::ucode_t ctl_o
);
  import cllm_pkg::*;

  function automatic ucode_t uw(logic acc, logic emit, dp_op_e op, cond_e c, upc_t tgt,
                                logic stay);
    ucode_t w;
    w.accept    = acc;
    w.emit      = emit;
    w.op        = op;
    w.cond      = c;
    w.target    = tgt;
    w.stay_else = stay;
    return w;
  endfunction

  always_comb begin
    case (upc_i)
      STEP_FETCH:      ctl_o = uw(1'b1, 1'b0, OP_NOP, C_IN_VALID, STEP_DISPATCH, 1'b1);
      STEP_DISPATCH:   ctl_o = uw(1'b0, 1'b0, OP_NOP, C_IS_DEL, STEP_DELETE, 1'b0);
      STEP_CHECK_FREE: ctl_o = uw(1'b0, 1'b0, OP_NOP, C_FREE_EMPTY, STEP_FULL, 1'b0);
      STEP_ALLOC:      ctl_o = uw(1'b0, 1'b0, OP_ALLOC, C_FRONT, STEP_LINK_FRONT, 1'b0);
      STEP_WALK_INIT:  ctl_o = uw(1'b0, 1'b0, OP_WALK_INIT, C_NEVER, STEP_FETCH, 1'b0);
      STEP_WALK:       ctl_o = uw(1'b0, 1'b0, OP_WALK, C_WALK_MORE, STEP_WALK, 1'b0);
      STEP_LINK_NEW:   ctl_o = uw(1'b0, 1'b0, OP_LINK_NEW, C_NEVER, STEP_FETCH, 1'b0);
      STEP_LINK_CUR:   ctl_o = uw(1'b0, 1'b0, OP_LINK_CUR, C_ALWAYS, STEP_EMIT, 1'b0);
      STEP_LINK_FRONT: ctl_o = uw(1'b0, 1'b0, OP_LINK_FRONT, C_ALWAYS, STEP_EMIT, 1'b0);
      STEP_DELETE:     ctl_o = uw(1'b0, 1'b0, OP_DELETE, C_ALWAYS, STEP_EMIT, 1'b0);
      STEP_FULL:       ctl_o = uw(1'b0, 1'b0, OP_FULL, C_NEVER, STEP_FETCH, 1'b0);
      STEP_EMIT:       ctl_o = uw(1'b0, 1'b1, OP_NOP, C_OUT_FREE, STEP_FETCH, 1'b1);
      default:         ctl_o = uw(1'b0, 1'b0, OP_NOP, C_ALWAYS, STEP_FETCH, 1'b0);
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/cllm_datapath.sv */
// slot pool, list heads, free list and walk registers driven by the microprogram
`default_nettype none

module cllm_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_fire_i,
  input  wire [1:0]             action_i,
  input  wire [1:0]             list_sel_i,
  input  wire [7:0]             element_i,
  input  wire [4:0]             position_i,
  input  cllm_pkg::dp_op_e      op_i,
  output cllm_pkg::dp_flags_t   flags_o,
  output cllm_pkg::dp_result_t  result_o
);
  import cllm_pkg::*;

  elem_t   elem_q [SLOTS];
  ptr_t    link_q [SLOTS];
  ptr_t    head_q [NUM_LISTS];
  ptr_t    free_q;

  action_e             act_q;
  logic [LIST_W-1:0]   sel_q;
  elem_t               byte_q;
  ptr_t                pos_q;
  ptr_t                h_q, s_q, cur_q, nxt_q;
  logic [STEP_W-1:0]   steps_q;
  status_e             status_q;
  ptr_t                slot_q;
  elem_t               removed_q;

  ptr_t  rd_ptr;
  ptr_t  rd_link;
  logic  head_ok;
  logic  walk_more;
  logic  pos_hit;

  // single read port on the link array
  always_comb begin
    case (op_i)
      OP_ALLOC: rd_ptr = s_q;
      OP_WALK:  rd_ptr = nxt_q;
      default:  rd_ptr = h_q;
    endcase
  end

  assign rd_link   = valid_or_null(link_q[rd_ptr[SLOT_W-1:0]]);
  assign head_ok   = is_slot(h_q);
  assign pos_hit   = (act_q == ACT_INS_POS) && (nxt_q == pos_q);
  assign walk_more = is_slot(nxt_q) && !pos_hit && (steps_q != STEP_W'(SLOTS));

  assign flags_o.is_del     = (act_q == ACT_DEL_FRONT);
  assign flags_o.free_empty = !is_slot(free_q);
  assign flags_o.front      = !head_ok || (act_q == ACT_INS_FRONT) ||
                              ((act_q == ACT_INS_POS) &&
                               ((pos_q == PTR_NULL) || (pos_q == h_q)));
  assign flags_o.walk_more  = walk_more;

  assign result_o.status   = status_q;
  assign result_o.slot     = slot_q;
  assign result_o.removed  = removed_q;
  assign result_o.new_head = valid_or_null(head_q[sel_q]);

  // pool and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        elem_q[i] <= '0;
        link_q[i] <= PTR_W'(i - 1);
      end
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_q[i] <= PTR_NULL;
      end
      free_q <= PTR_W'(SLOTS - 1);
    end else begin
      case (op_i)
        OP_ALLOC: begin
          free_q                   <= rd_link;
          elem_q[s_q[SLOT_W-1:0]]  <= byte_q;
        end
        OP_LINK_NEW: begin
          link_q[s_q[SLOT_W-1:0]] <= pos_hit ? nxt_q : PTR_NULL;
        end
        OP_LINK_CUR: begin
          link_q[cur_q[SLOT_W-1:0]] <= s_q;
        end
        OP_LINK_FRONT: begin
          link_q[s_q[SLOT_W-1:0]] <= head_ok ? h_q : PTR_NULL;
          head_q[sel_q]           <= s_q;
        end
        OP_DELETE: begin
          if (head_ok) begin
            elem_q[h_q[SLOT_W-1:0]] <= '0;
            link_q[h_q[SLOT_W-1:0]] <= valid_or_null(free_q);
            head_q[sel_q]           <= rd_link;
            free_q                  <= h_q;
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      act_q     <= action_e'(action_i);
      sel_q     <= list_sel_i[LIST_W-1:0];
      byte_q    <= element_i;
      pos_q     <= position_i;
      h_q       <= head_q[list_sel_i[LIST_W-1:0]];
      s_q       <= free_q;
      status_q  <= ST_DONE;
      slot_q    <= PTR_NULL;
      removed_q <= '0;
    end else begin
      case (op_i)
        OP_ALLOC: begin
          slot_q <= s_q;
        end
        OP_WALK_INIT: begin
          cur_q   <= h_q;
          nxt_q   <= rd_link;
          steps_q <= '0;
        end
        OP_WALK: begin
          if (walk_more) begin
            cur_q   <= nxt_q;
            nxt_q   <= rd_link;
            steps_q <= steps_q + 1'b1;
          end
        end
        OP_DELETE: begin
          if (head_ok) begin
            removed_q <= elem_q[h_q[SLOT_W-1:0]];
            slot_q    <= h_q;
          end else begin
            status_q <= ST_EMPTY;
          end
        end
        OP_FULL: begin
          status_q <= ST_FULL;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cursor_linked_list_manager.sv */
// cursor linked list manager: a microcoded sequencer takes one item per pass
// every item runs fetch, dispatch; a delete then runs delete, emit; an insert runs
// check_free, then full, emit if the pool is full, else alloc, then link_front, emit
// for a front insert, else walk_init, walk (up to 16 links), link_new, link_cur, emit;
// an item is accepted only in fetch; a result not taken holds the sequencer in emit
// reset: async active low; slot i links to i-1, all heads empty, free head at the top slot
`default_nettype none

module cursor_linked_list_manager (
  input  wire        clk_i,
  input  wire        rst_ni,
  cllm_in_if.sink    in_i,
  cllm_out_if.source out_o
);
  import cllm_pkg::*;

  upc_t       upc_q, upc_d;
  ucode_t     ctl;
  dp_flags_t  flags;
  dp_result_t result;
  logic       in_fire;
  logic       out_free;
  logic       cond_hit;

  logic       out_valid_q;
  status_e    status_q;
  ptr_t       slot_q;
  elem_t      removed_q;
  ptr_t       new_head_q;

  cllm_ucode_rom u_rom (
    .upc_i (upc_q),
    .ctl_o (ctl)
  );

  cllm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .action_i   (in_i.action),
    .list_sel_i (in_i.list_sel),
    .element_i  (in_i.element),
    .position_i (in_i.position),
    .op_i       (ctl.op),
    .flags_o    (flags),
    .result_o   (result)
  );

  assign in_i.ready = ctl.accept;
  assign in_fire    = in_i.valid && ctl.accept;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    case (ctl.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_IN_VALID:   cond_hit = in_i.valid;
      C_IS_DEL:     cond_hit = flags.is_del;
      C_FREE_EMPTY: cond_hit = flags.free_empty;
      C_FRONT:      cond_hit = flags.front;
      C_WALK_MORE:  cond_hit = flags.walk_more;
      C_OUT_FREE:   cond_hit = out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      upc_d = ctl.target;
    end else if (ctl.stay_else) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= STEP_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (ctl.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded as the microprogram finishes an item
  always_ff @(posedge clk_i) begin
    if (ctl.emit && out_free) begin
      status_q   <= result.status;
      slot_q     <= result.slot;
      removed_q  <= result.removed;
      new_head_q <= result.new_head;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.slot            = slot_q;
  assign out_o.removed_element = removed_q;
  assign out_o.new_head        = new_head_q;

endmodule

`default_nettype wire
